// File: design/mdeu_pkg.sv
// ----------------------------------------------------------------------------
// mdeu_pkg
// Opcodes, function codes, memory-operation codes and shared types for the
// MIPS32 decode and execute unit.
// ----------------------------------------------------------------------------
package mdeu_pkg;

	localparam logic [5:0] OP_SPECIAL = 6'd0;
	localparam logic [5:0] OP_REGIMM  = 6'd1;
	localparam logic [5:0] OP_J       = 6'd2;
	localparam logic [5:0] OP_JAL     = 6'd3;
	localparam logic [5:0] OP_BEQ     = 6'd4;
	localparam logic [5:0] OP_BNE     = 6'd5;
	localparam logic [5:0] OP_BLEZ    = 6'd6;
	localparam logic [5:0] OP_BGTZ    = 6'd7;
	localparam logic [5:0] OP_ADDI    = 6'd8;
	localparam logic [5:0] OP_ADDIU   = 6'd9;
	localparam logic [5:0] OP_SLTI    = 6'd10;
	localparam logic [5:0] OP_ANDI    = 6'd12;
	localparam logic [5:0] OP_ORI     = 6'd13;
	localparam logic [5:0] OP_XORI    = 6'd14;
	localparam logic [5:0] OP_LUI     = 6'd15;
	localparam logic [5:0] OP_LB      = 6'd32;
	localparam logic [5:0] OP_LH      = 6'd33;
	localparam logic [5:0] OP_LW      = 6'd35;
	localparam logic [5:0] OP_SB      = 6'd40;
	localparam logic [5:0] OP_SH      = 6'd41;
	localparam logic [5:0] OP_SW      = 6'd43;

	localparam logic [5:0] FN_SLL     = 6'd0;
	localparam logic [5:0] FN_SRL     = 6'd2;
	localparam logic [5:0] FN_SRA     = 6'd3;
	localparam logic [5:0] FN_JR      = 6'd8;
	localparam logic [5:0] FN_JALR    = 6'd9;
	localparam logic [5:0] FN_SYSCALL = 6'd12;
	localparam logic [5:0] FN_MFHI    = 6'd16;
	localparam logic [5:0] FN_MTHI    = 6'd17;
	localparam logic [5:0] FN_MFLO    = 6'd18;
	localparam logic [5:0] FN_MTLO    = 6'd19;
	localparam logic [5:0] FN_MULT    = 6'd24;
	localparam logic [5:0] FN_MULTU   = 6'd25;
	localparam logic [5:0] FN_DIV     = 6'd26;
	localparam logic [5:0] FN_DIVU    = 6'd27;
	localparam logic [5:0] FN_ADD     = 6'd32;
	localparam logic [5:0] FN_ADDU    = 6'd33;
	localparam logic [5:0] FN_SUB     = 6'd34;
	localparam logic [5:0] FN_SUBU    = 6'd35;
	localparam logic [5:0] FN_AND     = 6'd36;
	localparam logic [5:0] FN_OR      = 6'd37;
	localparam logic [5:0] FN_XOR     = 6'd38;
	localparam logic [5:0] FN_NOR     = 6'd39;
	localparam logic [5:0] FN_SLT     = 6'd42;

	localparam logic [2:0] MEM_NONE = 3'd0;
	localparam logic [2:0] MEM_LB   = 3'd1;
	localparam logic [2:0] MEM_LH   = 3'd2;
	localparam logic [2:0] MEM_LW   = 3'd3;
	localparam logic [2:0] MEM_SB   = 3'd4;
	localparam logic [2:0] MEM_SH   = 3'd5;
	localparam logic [2:0] MEM_SW   = 3'd6;

	typedef enum logic [1:0] {
		MD_MULT,
		MD_MULTU,
		MD_DIV,
		MD_DIVU
	} md_op_t;

	typedef struct packed {
		logic   start;
		md_op_t op;
	} md_req_t;

	typedef struct packed {
		logic done;
		logic busy;
	} md_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WAIT,
		ST_OUT
	} seq_state_t;

endpackage

// File: design/mips_decode_execute_unit_top.sv
// ----------------------------------------------------------------------------
// mips_decode_execute_unit_top
// MIPS32 decode/execute stage with HI/LO registers.
// ----------------------------------------------------------------------------
// One instruction is taken at a time. ALU, load/store, MFHI/MFLO/MTHI/MTLO and
// other single-cycle instructions deliver their result in the cycle after
// acceptance. MULT, MULTU, DIV and DIVU run on a shared 33-bit add/subtract
// unit, one bit per cycle, and deliver after a final sign fix-up; a divide
// by zero skips the unit and returns like a single-cycle instruction. The
// input stalls until the result has been taken.
module mips_decode_execute_unit_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] instr,
	input  logic [31:0] rs_value,
	input  logic [31:0] rt_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] alu_result,
	output logic [4:0]  dest_reg,
	output logic        reg_write,
	output logic [2:0]  mem_op,
	output logic [31:0] store_data,
	output logic        overflow,
	output logic        div_by_zero,
	output logic        halt,
	output logic        bad_opcode
);
	import mdeu_pkg::*;

	seq_state_t  state_q, state_d;
	logic [31:0] hi_q, lo_q;
	logic [31:0] res;
	logic [4:0]  dst;
	logic        wr, ovf, hlt, bad, md_start;
	logic [2:0]  mop;
	logic [31:0] sd;
	md_op_t      md_op;
	md_req_t     req;
	md_stat_t    stat;
	logic [31:0] md_hi, md_lo;
	logic        accept, is_mt_hi, is_mt_lo, dz;

	mdeu_alu u_alu (
		.instr(instr), .a(rs_value), .b(rt_value), .hi(hi_q), .lo(lo_q),
		.alu_result(res), .dest_reg(dst), .reg_write(wr), .mem_op(mop),
		.store_data(sd), .overflow(ovf), .halt(hlt), .bad_opcode(bad),
		.md_start(md_start), .md_op(md_op)
	);

	assign accept    = in_valid && !in_stall;
	assign req.start = accept && md_start;
	assign req.op    = md_op;

	mdeu_muldiv u_md (
		.clk(clk), .arst_n(arst_n), .req(req), .a(rs_value), .b(rt_value),
		.stat(stat), .hi(md_hi), .lo(md_lo)
	);

	assign is_mt_hi = (instr[31:26] == OP_SPECIAL) && (instr[5:0] == FN_MTHI);
	assign is_mt_lo = (instr[31:26] == OP_SPECIAL) && (instr[5:0] == FN_MTLO);
	assign dz = (instr[31:26] == OP_SPECIAL) && (rt_value == 32'd0)
		&& ((instr[5:0] == FN_DIV) || (instr[5:0] == FN_DIVU));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = md_start ? ST_WAIT : ST_OUT;
			ST_WAIT: if (stat.done) state_d = ST_OUT;
			ST_OUT:  if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		out_valid = (state_q == ST_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hi_q    <= '0;
			lo_q    <= '0;
		end else begin
			state_q <= state_d;
			if (accept && is_mt_hi) hi_q <= rs_value;
			if (accept && is_mt_lo) lo_q <= rs_value;
			if (state_q == ST_WAIT && stat.done) begin
				hi_q <= md_hi;
				lo_q <= md_lo;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			alu_result  <= res;
			dest_reg    <= dst;
			reg_write   <= wr;
			mem_op      <= mop;
			store_data  <= sd;
			overflow    <= ovf;
			div_by_zero <= dz;
			halt        <= hlt;
			bad_opcode  <= bad;
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy |-> in_stall)
		else $error("accept while multiply/divide busy");
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> (state_q == ST_WAIT))
		else $error("unit finished outside wait state");
	a_out_after: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT && stat.done) |=> out_valid)
		else $error("result not presented after unit completion");
endmodule

// File: design/mdeu_muldiv.sv
// ----------------------------------------------------------------------------
// mdeu_muldiv
// Shared iterative unit: one 33-bit add/subtract per cycle does shift-add
// multiply or restoring divide on magnitudes; signs fixed at the end.
// ----------------------------------------------------------------------------
module mdeu_muldiv (
	input  logic            clk,
	input  logic            arst_n,
	input  mdeu_pkg::md_req_t  req,
	input  logic [31:0]     a,
	input  logic [31:0]     b,
	output mdeu_pkg::md_stat_t stat,
	output logic [31:0]     hi,
	output logic [31:0]     lo
);
	import mdeu_pkg::*;

	logic        busy_q;
	logic        fix_q;
	logic [5:0]  cnt_q;
	md_op_t      op_q;
	logic [31:0] acc_q;
	logic [31:0] lo_q;
	logic [31:0] b_q;
	logic        neg_q_q;
	logic        neg_r_q;
	logic        sgn;
	logic [31:0] ma;
	logic [31:0] mb;
	logic [32:0] sum;
	logic [32:0] diff;
	logic [63:0] prod_neg;

	assign sgn    = (req.op == MD_MULT) || (req.op == MD_DIV);
	assign ma     = (sgn && a[31]) ? (32'd0 - a) : a;
	assign mb     = (sgn && b[31]) ? (32'd0 - b) : b;
	assign sum    = {1'b0, acc_q} + ({1'b0, b_q} & {33{lo_q[0]}});
	assign diff   = {acc_q, lo_q[31]} - {1'b0, b_q};
	assign prod_neg = 64'd0 - {acc_q, lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			fix_q  <= 1'b0;
			cnt_q  <= 6'd32;
		end else if (busy_q) begin
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				fix_q  <= 1'b1;
			end
			cnt_q <= cnt_q - 6'd1;
		end else begin
			fix_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q    <= req.op;
			acc_q   <= '0;
			lo_q    <= ma;
			b_q     <= mb;
			neg_q_q <= sgn && (a[31] ^ b[31]);
			neg_r_q <= sgn && a[31];
		end else if (busy_q) begin
			if ((op_q == MD_DIV) || (op_q == MD_DIVU)) begin
				if (!diff[32]) begin
					acc_q <= diff[31:0];
					lo_q  <= {lo_q[30:0], 1'b1};
				end else begin
					acc_q <= {acc_q[30:0], lo_q[31]};
					lo_q  <= {lo_q[30:0], 1'b0};
				end
			end else begin
				acc_q <= sum[32:1];
				lo_q  <= {sum[0], lo_q[31:1]};
			end
		end else if (fix_q) begin
			if ((op_q == MD_DIV) || (op_q == MD_DIVU)) begin
				if (neg_q_q) lo_q <= 32'd0 - lo_q;
				if (neg_r_q) acc_q <= 32'd0 - acc_q;
			end else if (neg_q_q) begin
				acc_q <= prod_neg[63:32];
				lo_q  <= prod_neg[31:0];
			end
		end
	end

	logic fix_d_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fix_d_q <= 1'b0;
		else fix_d_q <= fix_q;
	end

	assign stat.done = fix_d_q;
	assign stat.busy = busy_q || fix_q;
	assign hi = acc_q;
	assign lo = lo_q;
endmodule

// File: design/mdeu_alu.sv
// ----------------------------------------------------------------------------
// mdeu_alu
// Decode and single-cycle execute of the integer subset, memory address
// forming and flag generation.
// ----------------------------------------------------------------------------
module mdeu_alu (
	input  logic [31:0] instr,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] hi,
	input  logic [31:0] lo,
	output logic [31:0] alu_result,
	output logic [4:0]  dest_reg,
	output logic        reg_write,
	output logic [2:0]  mem_op,
	output logic [31:0] store_data,
	output logic        overflow,
	output logic        halt,
	output logic        bad_opcode,
	output logic        md_start,
	output mdeu_pkg::md_op_t md_op
);
	import mdeu_pkg::*;

	logic [5:0]  op;
	logic [5:0]  fn;
	logic [4:0]  sh;
	logic [31:0] simm;
	logic [31:0] zimm;
	logic [31:0] sum_r;
	logic [31:0] sum_i;
	logic        ovf_r;
	logic        ovf_i;

	assign op    = instr[31:26];
	assign fn    = instr[5:0];
	assign sh    = instr[10:6];
	assign simm  = {{16{instr[15]}}, instr[15:0]};
	assign zimm  = {16'd0, instr[15:0]};
	assign sum_r = a + b;
	assign sum_i = a + simm;
	assign ovf_r = ~(a[31] ^ b[31]) & (a[31] ^ sum_r[31]);
	assign ovf_i = ~(a[31] ^ simm[31]) & (a[31] ^ sum_i[31]);

	always_comb begin
		alu_result = '0; dest_reg = '0; reg_write = 1'b0; mem_op = MEM_NONE;
		store_data = '0; overflow = 1'b0; halt = 1'b0; bad_opcode = 1'b0;
		md_start = 1'b0; md_op = MD_MULT;
		if (op == OP_SPECIAL) begin
			unique case (fn)
				FN_SLL: begin alu_result = b << sh; dest_reg = instr[15:11]; reg_write = 1'b1; end
				FN_SRL: begin alu_result = b >> sh; dest_reg = instr[15:11]; reg_write = 1'b1; end
				FN_SRA: begin
					alu_result = $signed(b) >>> sh; dest_reg = instr[15:11]; reg_write = 1'b1;
				end
				FN_JR, FN_JALR, FN_MTHI, FN_MTLO: ;
				FN_SYSCALL: halt = 1'b1;
				FN_MFHI: begin alu_result = hi; dest_reg = instr[15:11]; reg_write = 1'b1; end
				FN_MFLO: begin alu_result = lo; dest_reg = instr[15:11]; reg_write = 1'b1; end
				FN_MULT:  begin md_start = 1'b1; md_op = MD_MULT; end
				FN_MULTU: begin md_start = 1'b1; md_op = MD_MULTU; end
				FN_DIV:   begin md_start = (b != 32'd0); md_op = MD_DIV; end
				FN_DIVU:  begin md_start = (b != 32'd0); md_op = MD_DIVU; end
				FN_ADD: begin
					alu_result = sum_r; dest_reg = instr[15:11];
					overflow = ovf_r; reg_write = ~ovf_r;
				end
				FN_ADDU: begin alu_result = sum_r; dest_reg = instr[15:11]; reg_write = 1'b1; end
				FN_SUB, FN_SUBU: begin
					alu_result = a - b; dest_reg = instr[15:11]; reg_write = 1'b1;
				end
				FN_AND: begin alu_result = a & b; dest_reg = instr[15:11]; reg_write = 1'b1; end
				FN_OR:  begin alu_result = a | b; dest_reg = instr[15:11]; reg_write = 1'b1; end
				FN_XOR: begin alu_result = a ^ b; dest_reg = instr[15:11]; reg_write = 1'b1; end
				FN_NOR: begin alu_result = ~(a | b); dest_reg = instr[15:11]; reg_write = 1'b1; end
				FN_SLT: begin
					alu_result = {31'd0, $signed(a) < $signed(b)};
					dest_reg = instr[15:11]; reg_write = 1'b1;
				end
				default: bad_opcode = 1'b1;
			endcase
		end else begin
			unique case (op)
				OP_REGIMM: bad_opcode = (instr[20:16] > 5'd1);
				OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: ;
				OP_ADDI: begin
					alu_result = sum_i; dest_reg = instr[20:16];
					overflow = ovf_i; reg_write = ~ovf_i;
				end
				OP_ADDIU: begin alu_result = sum_i; dest_reg = instr[20:16]; reg_write = 1'b1; end
				OP_SLTI: begin
					alu_result = {31'd0, $signed(a) < $signed(simm)};
					dest_reg = instr[20:16]; reg_write = 1'b1;
				end
				OP_ANDI: begin alu_result = a & zimm; dest_reg = instr[20:16]; reg_write = 1'b1; end
				OP_ORI:  begin alu_result = a | zimm; dest_reg = instr[20:16]; reg_write = 1'b1; end
				OP_XORI: begin alu_result = a ^ zimm; dest_reg = instr[20:16]; reg_write = 1'b1; end
				OP_LUI: begin
					alu_result = {instr[15:0], 16'd0}; dest_reg = instr[20:16]; reg_write = 1'b1;
				end
				OP_LB: begin alu_result = sum_i; mem_op = MEM_LB; dest_reg = instr[20:16]; reg_write = 1'b1; end
				OP_LH: begin alu_result = sum_i; mem_op = MEM_LH; dest_reg = instr[20:16]; reg_write = 1'b1; end
				OP_LW: begin alu_result = sum_i; mem_op = MEM_LW; dest_reg = instr[20:16]; reg_write = 1'b1; end
				OP_SB: begin alu_result = sum_i; mem_op = MEM_SB; store_data = b; end
				OP_SH: begin alu_result = sum_i; mem_op = MEM_SH; store_data = b; end
				OP_SW: begin alu_result = sum_i; mem_op = MEM_SW; store_data = b; end
				default: bad_opcode = 1'b1;
			endcase
		end
	end
endmodule

// File: verif/tb_mips_decode_execute_unit_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mips_decode_execute_unit_top
// Self-checking testbench for the MIPS32 decode/execute unit. Instructions are
// driven through the valid/stall input channel and each result is checked
// field by field against an internal prediction that tracks HI and LO.
// ----------------------------------------------------------------------------
module tb_mips_decode_execute_unit_top;
	import mdeu_pkg::*;

	typedef struct packed {
		logic [31:0] alu_result;
		logic [4:0]  dest_reg;
		logic        reg_write;
		logic [2:0]  mem_op;
		logic [31:0] store_data;
		logic        overflow;
		logic        div_by_zero;
		logic        halt;
		logic        bad_opcode;
	} exec_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] instr = '0;
	logic [31:0] rs_value = '0;
	logic [31:0] rt_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] alu_result;
	logic [4:0]  dest_reg;
	logic        reg_write;
	logic [2:0]  mem_op;
	logic [31:0] store_data;
	logic        overflow;
	logic        div_by_zero;
	logic        halt;
	logic        bad_opcode;

	logic [31:0]  model_hi = '0;
	logic [31:0]  model_lo = '0;
	exec_result_t pending_results[$];
	int           error_count = 0;
	int           result_count = 0;
	int           sent_count = 0;
	int           hold_cycles = 0;
	bit           rx_idle_enable = 1'b1;

	mips_decode_execute_unit_top DUT (.*);

	always #2 clk = ~clk;

	initial begin
		#4000000;
		$display("tb_mips_decode_execute_unit_top: done, errors");
		$finish;
	end

	function automatic logic add_overflows(logic [31:0] a, logic [31:0] b);
		logic [31:0] s;
		s = a + b;
		return (a[31] == b[31]) && (s[31] != a[31]);
	endfunction

	function automatic exec_result_t predict_exec(logic [31:0] ir, logic [31:0] a,
			logic [31:0] b);
		exec_result_t r;
		logic [5:0]  op;
		logic [5:0]  fn;
		logic [4:0]  sh;
		logic [31:0] simm;
		logic [31:0] zimm;
		logic signed [63:0] sp;
		logic [63:0] up;
		logic [31:0] ma;
		logic [31:0] mb;
		logic [31:0] q;
		logic [31:0] rm;
		op = ir[31:26];
		fn = ir[5:0];
		sh = ir[10:6];
		simm = {{16{ir[15]}}, ir[15:0]};
		zimm = {16'h0, ir[15:0]};
		r = '0;
		if (op == OP_SPECIAL) begin
			r.dest_reg = ir[15:11];
			r.reg_write = 1'b1;
			case (fn)
				FN_SLL: r.alu_result = b << sh;
				FN_SRL: r.alu_result = b >> sh;
				FN_SRA: r.alu_result = $signed(b) >>> sh;
				FN_JR, FN_JALR: begin
					r.reg_write = 0; r.dest_reg = 0;
				end
				FN_SYSCALL: begin
					r.reg_write = 0; r.dest_reg = 0; r.halt = 1;
				end
				FN_MFHI: r.alu_result = model_hi;
				FN_MFLO: r.alu_result = model_lo;
				FN_MTHI: begin
					r.reg_write = 0; r.dest_reg = 0; model_hi = a;
				end
				FN_MTLO: begin
					r.reg_write = 0; r.dest_reg = 0; model_lo = a;
				end
				FN_MULT: begin
					sp = $signed(a) * $signed(b);
					{model_hi, model_lo} = sp;
					r.reg_write = 0; r.dest_reg = 0;
				end
				FN_MULTU: begin
					up = {32'h0, a} * {32'h0, b};
					{model_hi, model_lo} = up;
					r.reg_write = 0; r.dest_reg = 0;
				end
				FN_DIV: begin
					r.reg_write = 0; r.dest_reg = 0;
					if (b == 0) r.div_by_zero = 1;
					else begin
						ma = a[31] ? -a : a;
						mb = b[31] ? -b : b;
						q = ma / mb;
						rm = ma % mb;
						model_lo = (a[31] ^ b[31]) ? -q : q;
						model_hi = a[31] ? -rm : rm;
					end
				end
				FN_DIVU: begin
					r.reg_write = 0; r.dest_reg = 0;
					if (b == 0) r.div_by_zero = 1;
					else begin
						model_lo = a / b;
						model_hi = a % b;
					end
				end
				FN_ADD: begin
					r.alu_result = a + b;
					r.overflow = add_overflows(a, b);
					if (r.overflow) r.reg_write = 0;
				end
				FN_ADDU: r.alu_result = a + b;
				FN_SUB, FN_SUBU: r.alu_result = a - b;
				FN_AND: r.alu_result = a & b;
				FN_OR: r.alu_result = a | b;
				FN_XOR: r.alu_result = a ^ b;
				FN_NOR: r.alu_result = ~(a | b);
				FN_SLT: r.alu_result = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
				default: r.bad_opcode = 1;
			endcase
		end else if (op == OP_REGIMM) begin
			if (ir[20:16] > 5'd1) r.bad_opcode = 1;
		end else begin
			r.dest_reg = ir[20:16];
			r.reg_write = 1'b1;
			case (op)
				OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: begin
					r.reg_write = 0; r.dest_reg = 0;
				end
				OP_ADDI: begin
					r.alu_result = a + simm;
					r.overflow = add_overflows(a, simm);
					if (r.overflow) r.reg_write = 0;
				end
				OP_ADDIU: r.alu_result = a + simm;
				OP_SLTI: r.alu_result = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
				OP_ANDI: r.alu_result = a & zimm;
				OP_ORI: r.alu_result = a | zimm;
				OP_XORI: r.alu_result = a ^ zimm;
				OP_LUI: r.alu_result = zimm << 16;
				OP_LB: begin r.alu_result = a + simm; r.mem_op = MEM_LB; end
				OP_LH: begin r.alu_result = a + simm; r.mem_op = MEM_LH; end
				OP_LW: begin r.alu_result = a + simm; r.mem_op = MEM_LW; end
				OP_SB, OP_SH, OP_SW: begin
					r.alu_result = a + simm;
					r.mem_op = (op == OP_SB) ? MEM_SB : (op == OP_SH) ? MEM_SH : MEM_SW;
					r.store_data = b;
					r.reg_write = 0; r.dest_reg = 0;
				end
				default: r.bad_opcode = 1;
			endcase
		end
		if (r.bad_opcode) r = '0 | 1'b1;
		return r;
	endfunction

	task automatic send_instr(logic [31:0] ir, logic [31:0] a, logic [31:0] b,
			bit gaps = 1'b1);
		int gap;
		gap = gaps ? $urandom_range(0, 15) : 0;
		if (gaps && $urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		instr <= ir;
		rs_value <= a;
		rt_value <= b;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(predict_exec(ir, a, b));
		sent_count++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// receiver stall: random per result, or a long hold when requested
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			w = rx_idle_enable ? $urandom_range(0, 15) : 0;
			if (w > 0) begin
				out_stall <= 1'b1;
				repeat (w) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		exec_result_t got;
		exec_result_t exp;
		if (arst_n && out_valid && !out_stall) begin
			got = {alu_result, dest_reg, reg_write, mem_op, store_data, overflow,
				div_by_zero, halt, bad_opcode};
			result_count++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected transaction, actual %h", $time, got);
				error_count++;
			end else begin
				exp = pending_results.pop_front();
				if (got.alu_result !== exp.alu_result) begin
					$display("%0t: alu_result expected %h actual %h", $time,
						exp.alu_result, got.alu_result);
					error_count++;
				end
				if (got.dest_reg !== exp.dest_reg) begin
					$display("%0t: dest_reg expected %0d actual %0d", $time,
						exp.dest_reg, got.dest_reg);
					error_count++;
				end
				if (got.reg_write !== exp.reg_write) begin
					$display("%0t: reg_write expected %b actual %b", $time,
						exp.reg_write, got.reg_write);
					error_count++;
				end
				if (got.mem_op !== exp.mem_op) begin
					$display("%0t: mem_op expected %0d actual %0d", $time,
						exp.mem_op, got.mem_op);
					error_count++;
				end
				if (got.store_data !== exp.store_data) begin
					$display("%0t: store_data expected %h actual %h", $time,
						exp.store_data, got.store_data);
					error_count++;
				end
				if (got.overflow !== exp.overflow) begin
					$display("%0t: overflow expected %b actual %b", $time,
						exp.overflow, got.overflow);
					error_count++;
				end
				if (got.div_by_zero !== exp.div_by_zero) begin
					$display("%0t: div_by_zero expected %b actual %b", $time,
						exp.div_by_zero, got.div_by_zero);
					error_count++;
				end
				if (got.halt !== exp.halt) begin
					$display("%0t: halt expected %b actual %b", $time,
						exp.halt, got.halt);
					error_count++;
				end
				if (got.bad_opcode !== exp.bad_opcode) begin
					$display("%0t: bad_opcode expected %b actual %b", $time,
						exp.bad_opcode, got.bad_opcode);
					error_count++;
				end
			end
		end
	end

	function automatic logic [31:0] rtype(logic [5:0] fn, logic [4:0] rd, logic [4:0] sh);
		return {OP_SPECIAL, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
			rd, sh, fn};
	endfunction

	function automatic logic [31:0] itype(logic [5:0] op, logic [15:0] imm);
		return {op, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), imm};
	endfunction

	function automatic logic [31:0] edge_value();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'hffffffff;
			2: return 32'h80000000;
			3: return 32'h7fffffff;
			4: return 32'h1;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		send_instr(rtype(FN_ADD, 5'd31, 5'd0), 32'h7fffffff, 32'h1);
		send_instr(rtype(FN_ADD, 5'd0, 5'd0), 32'h80000000, 32'h80000000);
		send_instr(itype(OP_ADDI, 16'h8000), 32'h80000000, 0);
		send_instr(itype(OP_ADDI, 16'h0001), 32'h7fffffff, 0);
		send_instr(rtype(FN_SLL, 5'd1, 5'd31), 0, 32'hffffffff);
		send_instr(rtype(FN_SRA, 5'd2, 5'd31), 0, 32'h80000000);
		send_instr(rtype(FN_SRL, 5'd3, 5'd31), 0, 32'h80000000);
		send_instr(itype(OP_ANDI, 16'hffff), 32'hffffffff, 0);
		send_instr(itype(OP_LUI, 16'hffff), 0, 0);
		send_instr(itype(OP_SLTI, 16'h8000), 32'h80000000, 0);
		send_instr(rtype(FN_DIV, 5'd0, 5'd0), 32'h80000000, 32'hffffffff);
		send_instr(rtype(FN_MFHI, 5'd4, 5'd0), 0, 0);
		send_instr(rtype(FN_MFLO, 5'd5, 5'd0), 0, 0);
		send_instr(rtype(FN_DIVU, 5'd0, 5'd0), 32'h1234, 32'h0);
		send_instr(rtype(FN_MFLO, 5'd5, 5'd0), 0, 0);
		send_instr(rtype(FN_DIV, 5'd0, 5'd0), 32'hfffffff9, 32'h2);
		send_instr(rtype(FN_MFHI, 5'd6, 5'd0), 0, 0);
		send_instr(rtype(FN_MULT, 5'd0, 5'd0), 32'h80000000, 32'h80000000);
		send_instr(rtype(FN_MFHI, 5'd7, 5'd0), 0, 0);
		send_instr(rtype(FN_MULTU, 5'd0, 5'd0), 32'hffffffff, 32'hffffffff);
		send_instr(rtype(FN_MFLO, 5'd8, 5'd0), 0, 0);
		send_instr(rtype(FN_SYSCALL, 5'd0, 5'd0), 0, 0);
		send_instr(itype(OP_SW, 16'hfffc), 32'h100, 32'hdeadbeef);
		send_instr({OP_REGIMM, 5'd3, 5'd2, 16'h0}, 0, 0);
		send_instr({6'd63, 26'h3ffffff}, 32'hffffffff, 32'hffffffff);
		wait_drained();
	endtask

	function automatic logic [31:0] random_instr();
		logic [5:0] known_fn[23] = '{FN_SLL, FN_SRL, FN_SRA, FN_JR, FN_JALR, FN_SYSCALL,
			FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT, FN_MULTU, FN_DIV, FN_DIVU,
			FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT};
		logic [5:0] known_op[20] = '{OP_REGIMM, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ,
			OP_BGTZ, OP_ADDI, OP_ADDIU, OP_SLTI, OP_ANDI, OP_ORI, OP_XORI, OP_LUI,
			OP_LB, OP_LH, OP_LW, OP_SB, OP_SH, OP_SW};
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: w[31:26] = OP_SPECIAL;
			4, 5, 6, 7, 8: w[31:26] = known_op[$urandom_range(0, 19)];
			default: ;
		endcase
		if (w[31:26] == OP_SPECIAL && $urandom_range(0, 9) != 0)
			w[5:0] = known_fn[$urandom_range(0, 22)];
		if (w[31:26] == OP_REGIMM && $urandom_range(0, 2) != 0)
			w[20:16] = 5'($urandom_range(0, 1));
		return w;
	endfunction

	task automatic test_random(int n);
		repeat (n) send_instr(random_instr(), edge_value(), edge_value());
	endtask

	task automatic test_backpressure();
		hold_cycles = 200;
		repeat (20) send_instr(random_instr(), edge_value(), edge_value(), 1'b0);
		wait_drained();
	endtask

	task automatic test_streaming();
		rx_idle_enable = 1'b0;
		repeat (100) send_instr(random_instr(), edge_value(), edge_value(), 1'b0);
		wait_drained();
		rx_idle_enable = 1'b1;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(600);
		test_backpressure();
		test_streaming();
		test_random(660);
		wait_drained();
		repeat (50) @(posedge clk);
		$display("Ran %0d instructions (directed corners, random mix, long output hold,",
			sent_count);
		$display("back-to-back streaming); %0d results checked.", result_count);
		if (error_count == 0)
			$display("tb_mips_decode_execute_unit_top: done, clean");
		else
			$display("tb_mips_decode_execute_unit_top: done, errors");
		$finish;
	end

endmodule
